[hw/rtl/best_fit_range_allocator_defines.svh]
// ---------------------------------------------------------------------------
// best fit range allocator assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bfra_pkg.sv]
// ---------------------------------------------------------------------------
// bfra_pkg
// constants, entry type and status codes of the best fit range allocator
// ---------------------------------------------------------------------------
package bfra_pkg;

  localparam int FREE_DEPTH  = 64;
  localparam int LIVE_DEPTH  = 63;
  localparam int ALIGN_BYTES = 256;

  localparam int FREE_AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int LIVE_AW = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;
  localparam int SCAN_N  = (FREE_DEPTH > LIVE_DEPTH) ? FREE_DEPTH : LIVE_DEPTH;
  localparam int SCAN_AW = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
  localparam int CNT_W   = $clog2(SCAN_N + 1);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO      = 3'd1;
  localparam logic [2:0] ST_NO_FIT    = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef struct packed {
    logic [31:0] len;
    logic [31:0] off;
  } ent_t;

endpackage

[hw/rtl/bfra_ram.sv]
// ---------------------------------------------------------------------------
// bfra_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module bfra_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/best_fit_range_allocator.sv]
// allocate: one pass over the free ram from start to done
// release: live ram pass, then free ram pass
// zero size items skip both scans; one item at a time, busy high while working
// done pulses one cycle with the result; the receiver cannot stall
// synchronous reset empties both tables and clears the slab size; no clearing pass
// ---------------------------------------------------------------------------
// best_fit_range_allocator
// best fit sub-allocator over one slab with a free range ram and a live block ram
// ---------------------------------------------------------------------------
`include "best_fit_range_allocator_defines.svh"

module best_fit_range_allocator
  import bfra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [31:0] request_bytes,
  input  logic [31:0] release_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] block_offset,
  output logic [31:0] block_bytes,
  output logic [31:0] free_total,
  output logic [31:0] live_total
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ZERO   = 3'd1;
  localparam logic [2:0] S_FSCAN  = 3'd2;
  localparam logic [2:0] S_AWRITE = 3'd3;
  localparam logic [2:0] S_LSCAN  = 3'd4;
  localparam logic [2:0] S_RSCAN  = 3'd5;
  localparam logic [2:0] S_RWRITE = 3'd6;

  logic [2:0]         state;
  logic [CNT_W-1:0]   cnt;
  logic               pend;
  logic [SCAN_AW-1:0] pidx;
  logic [32:0]        need;
  logic [31:0]        roff;

  logic               best_found;
  logic [FREE_AW-1:0] best_idx;
  logic [31:0]        best_off;
  logic [31:0]        best_len;
  logic               slot_found;
  logic [LIVE_AW-1:0] slot;

  logic               hit_found;
  logic [LIVE_AW-1:0] hit_idx;
  logic [31:0]        hit_len;
  logic [32:0]        up_target;
  logic               lo_found;
  logic [FREE_AW-1:0] lo_idx;
  logic [31:0]        lo_off;
  logic [31:0]        lo_len;
  logic               up_found;
  logic [FREE_AW-1:0] up_idx;
  logic [31:0]        up_len;
  logic               emp_found;
  logic [FREE_AW-1:0] emp_idx;

  logic [FREE_DEPTH-1:0] free_valid;
  logic [FREE_DEPTH-1:0] free_valid_next;
  logic [LIVE_DEPTH-1:0] live_valid;

  logic               fw_en;
  logic [FREE_AW-1:0] fw_addr;
  ent_t               fw_data;
  logic               fr_en;
  logic [FREE_AW-1:0] fr_addr;
  ent_t               free_rd;
  logic               lw_en;
  logic [LIVE_AW-1:0] lw_addr;
  ent_t               lw_data;
  logic               lr_en;
  logic [LIVE_AW-1:0] lr_addr;
  ent_t               live_rd;

  logic        cfg_fire;
  logic [31:0] slab_al;
  logic [32:0] need_w;
  logic        a_ok;
  logic        f_v;
  logic        f_fit;
  logic        f_better;
  logic        r_lo;
  logic        r_up;
  logic [31:0] new_off;
  logic [31:0] new_len;
  logic [32:0] live_add;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign slab_al   = 32'((cfg_data / ALIGN_BYTES) * ALIGN_BYTES);
  assign need_w    = 33'((({1'b0, request_bytes} + 33'(ALIGN_BYTES - 1)) / ALIGN_BYTES)
                         * ALIGN_BYTES);
  assign a_ok      = best_found && slot_found;

  assign f_v      = free_valid[pidx[FREE_AW-1:0]];
  assign f_fit    = f_v && ({1'b0, free_rd.len} >= need);
  assign f_better = !best_found || (free_rd.len < best_len) ||
                    ((free_rd.len == best_len) && (free_rd.off < best_off));
  assign r_lo     = f_v && !lo_found &&
                    (({1'b0, free_rd.off} + {1'b0, free_rd.len}) == {1'b0, roff});
  assign r_up     = f_v && !up_found && ({1'b0, free_rd.off} == up_target);
  assign new_off  = lo_found ? lo_off : roff;
  assign new_len  = hit_len + (lo_found ? lo_len : 32'd0) + (up_found ? up_len : 32'd0);
  assign live_add = {1'b0, live_total} + need;

  always_comb begin
    fw_en   = 1'b0;
    fw_addr = best_idx;
    fw_data = '{len: best_len - need[31:0], off: best_off + need[31:0]};
    if (cfg_fire) begin
      fw_en   = 1'b1;
      fw_addr = '0;
      fw_data = '{len: slab_al, off: 32'd0};
    end else if (state == S_AWRITE) begin
      fw_en = a_ok && (best_len != need[31:0]);
    end else if (state == S_RWRITE) begin
      fw_en   = emp_found;
      fw_addr = emp_idx;
      fw_data = '{len: new_len, off: new_off};
    end
  end

  always_comb begin
    free_valid_next = free_valid;
    if (cfg_fire) begin
      free_valid_next    = '0;
      free_valid_next[0] = (slab_al != 32'd0);
    end else if (state == S_AWRITE) begin
      if (a_ok && (best_len == need[31:0])) begin
        free_valid_next[best_idx] = 1'b0;
      end
    end else if (state == S_RWRITE) begin
      if (lo_found) begin
        free_valid_next[lo_idx] = 1'b0;
      end
      if (up_found) begin
        free_valid_next[up_idx] = 1'b0;
      end
      if (emp_found) begin
        free_valid_next[emp_idx] = 1'b1;
      end
    end
  end

  assign fr_en   = ((state == S_FSCAN) || (state == S_RSCAN)) && (cnt < CNT_W'(FREE_DEPTH));
  assign fr_addr = cnt[FREE_AW-1:0];
  assign lw_en   = (state == S_AWRITE) && a_ok;
  assign lw_addr = slot;
  assign lw_data = '{len: need[31:0], off: best_off};
  assign lr_en   = (state == S_LSCAN) && (cnt < CNT_W'(LIVE_DEPTH));
  assign lr_addr = cnt[LIVE_AW-1:0];

  bfra_ram #(.DEPTH(FREE_DEPTH), .WIDTH($bits(ent_t)), .AW(FREE_AW)) u_free_ram (
    .clk   (clk),
    .we    (fw_en),
    .waddr (fw_addr),
    .wdata (fw_data),
    .re    (fr_en),
    .raddr (fr_addr),
    .rdata (free_rd)
  );

  bfra_ram #(.DEPTH(LIVE_DEPTH), .WIDTH($bits(ent_t)), .AW(LIVE_AW)) u_live_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .re    (lr_en),
    .raddr (lr_addr),
    .rdata (live_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      pend       <= 1'b0;
      free_valid <= '0;
      live_valid <= '0;
      live_total <= '0;
      free_total <= '0;
    end else begin
      done       <= 1'b0;
      free_valid <= free_valid_next;
      if (cfg_fire) begin
        live_valid    <= '0;
        live_total    <= '0;
        free_total    <= slab_al;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            need       <= need_w;
            roff       <= release_offset;
            cnt        <= '0;
            pend       <= 1'b0;
            best_found <= 1'b0;
            slot_found <= 1'b0;
            hit_found  <= 1'b0;
            if (request_bytes == 32'd0) begin
              state <= S_ZERO;
            end else if (kind == KIND_ALLOC) begin
              state <= S_FSCAN;
            end else begin
              state <= S_LSCAN;
            end
          end
        end
        S_ZERO: begin
          done         <= 1'b1;
          status       <= ST_ZERO;
          block_offset <= '0;
          block_bytes  <= '0;
          state        <= S_IDLE;
        end
        S_FSCAN: begin
          if (cnt < CNT_W'(SCAN_N)) begin
            cnt  <= cnt + 1'b1;
            pidx <= cnt[SCAN_AW-1:0];
            if (!slot_found && (cnt < CNT_W'(LIVE_DEPTH)) && !live_valid[cnt[LIVE_AW-1:0]])
            begin
              slot_found <= 1'b1;
              slot       <= cnt[LIVE_AW-1:0];
            end
          end
          pend <= fr_en;
          if (pend && f_fit && f_better) begin
            best_found <= 1'b1;
            best_idx   <= pidx[FREE_AW-1:0];
            best_off   <= free_rd.off;
            best_len   <= free_rd.len;
          end
          if ((cnt == CNT_W'(SCAN_N)) && !pend) begin
            state <= S_AWRITE;
          end
        end
        S_AWRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
          if (!best_found) begin
            status       <= ST_NO_FIT;
            block_offset <= '0;
            block_bytes  <= '0;
          end else if (!slot_found) begin
            status       <= ST_FULL;
            block_offset <= '0;
            block_bytes  <= '0;
          end else begin
            status           <= ST_OK;
            block_offset     <= best_off;
            block_bytes      <= need[31:0];
            live_valid[slot] <= 1'b1;
            free_total       <= free_total - need[31:0];
            live_total       <= live_add[32] ? 32'hFFFF_FFFF : live_add[31:0];
          end
        end
        S_LSCAN: begin
          if (cnt < CNT_W'(LIVE_DEPTH)) begin
            cnt  <= cnt + 1'b1;
            pidx <= cnt[SCAN_AW-1:0];
          end
          pend <= lr_en;
          if (pend && !hit_found && live_valid[pidx[LIVE_AW-1:0]] && (live_rd.off == roff))
          begin
            hit_found <= 1'b1;
            hit_idx   <= pidx[LIVE_AW-1:0];
            hit_len   <= live_rd.len;
            up_target <= {1'b0, roff} + {1'b0, live_rd.len};
          end
          if ((cnt == CNT_W'(LIVE_DEPTH)) && !pend) begin
            cnt       <= '0;
            lo_found  <= 1'b0;
            up_found  <= 1'b0;
            emp_found <= 1'b0;
            if (!hit_found) begin
              done         <= 1'b1;
              status       <= ST_NOT_FOUND;
              block_offset <= '0;
              block_bytes  <= '0;
              state        <= S_IDLE;
            end else begin
              live_valid[hit_idx] <= 1'b0;
              live_total <= (live_total >= hit_len) ? live_total - hit_len : 32'd0;
              state      <= S_RSCAN;
            end
          end
        end
        S_RSCAN: begin
          if (cnt < CNT_W'(FREE_DEPTH)) begin
            cnt  <= cnt + 1'b1;
            pidx <= cnt[SCAN_AW-1:0];
          end
          pend <= fr_en;
          if (pend) begin
            if (r_lo) begin
              lo_found <= 1'b1;
              lo_idx   <= pidx[FREE_AW-1:0];
              lo_off   <= free_rd.off;
              lo_len   <= free_rd.len;
            end
            if (r_up) begin
              up_found <= 1'b1;
              up_idx   <= pidx[FREE_AW-1:0];
              up_len   <= free_rd.len;
            end
            if (!emp_found && (!f_v || r_lo || r_up)) begin
              emp_found <= 1'b1;
              emp_idx   <= pidx[FREE_AW-1:0];
            end
          end
          if ((cnt == CNT_W'(FREE_DEPTH)) && !pend) begin
            state <= S_RWRITE;
          end
        end
        S_RWRITE: begin
          done         <= 1'b1;
          status       <= ST_OK;
          block_offset <= roff;
          block_bytes  <= hit_len;
          state        <= S_IDLE;
          if (emp_found) begin
            free_total <= free_total + hit_len;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BFRA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `BFRA_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a transaction in flight")
  `BFRA_ASSERT_IMP(a_fail_zero, done && (status != ST_OK),
                   (block_offset == 32'd0) && (block_bytes == 32'd0),
                   "failed transaction reports a block")
  `BFRA_ASSERT_IMP(a_ok_bytes, done && (status == ST_OK), block_bytes != 32'd0,
                   "ok transaction with empty block")

endmodule

[test/tb_best_fit_range_allocator.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_best_fit_range_allocator
// self-checking bench: drives allocate and release commands with random gaps,
// predicts each outcome with a behavioral free/live table model and compares
// every done strobe, all fields at once, against the oldest prediction
// ---------------------------------------------------------------------------
module tb_best_fit_range_allocator;
  import bfra_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] offset;
    logic [31:0] bytes;
    logic [31:0] free_sum;
    logic [31:0] live_sum;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        kind = KIND_ALLOC;
  logic [31:0] request_bytes = '0;
  logic [31:0] release_offset = '0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        busy, cfg_ready, done;
  logic [2:0]  status;
  logic [31:0] block_offset, block_bytes, free_total, live_total;

  always #1 clk = ~clk;

  best_fit_range_allocator i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .request_bytes(request_bytes), .release_offset(release_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .status(status), .block_offset(block_offset),
    .block_bytes(block_bytes), .free_total(free_total), .live_total(live_total)
  );

  // allocator shadow state
  logic [31:0] slab_bytes;
  ent_t        free_ent [FREE_DEPTH];
  logic        free_ok  [FREE_DEPTH];
  ent_t        live_ent [LIVE_DEPTH];
  logic        live_ok  [LIVE_DEPTH];
  logic [31:0] live_bytes;

  outcome_t    pending_outcomes[$];
  int          mismatches = 0;
  int          send_gap_pct = 0;
  logic [31:0] granted[$];

  function automatic void tables_reinit(logic [31:0] slab);
    slab_bytes = slab & ~32'(ALIGN_BYTES - 1);
    for (int i = 0; i < FREE_DEPTH; i++) begin
      free_ent[i] = '0;
      free_ok[i] = 1'b0;
    end
    for (int i = 0; i < LIVE_DEPTH; i++) begin
      live_ent[i] = '0;
      live_ok[i] = 1'b0;
    end
    live_bytes = '0;
    if (slab_bytes != 0) begin
      free_ent[0].off = '0;
      free_ent[0].len = slab_bytes;
      free_ok[0] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] free_bytes_sum();
    logic [63:0] s;
    s = '0;
    for (int i = 0; i < FREE_DEPTH; i++)
      if (free_ok[i]) s += 64'(free_ent[i].len);
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void free_range_merge(logic [63:0] off, logic [63:0] len);
    int slot;
    slot = -1;
    for (int i = 0; i < FREE_DEPTH; i++)
      if (free_ok[i] && 64'(free_ent[i].off) + 64'(free_ent[i].len) == off) begin
        off = 64'(free_ent[i].off);
        len += 64'(free_ent[i].len);
        free_ok[i] = 1'b0;
        break;
      end
    for (int i = 0; i < FREE_DEPTH; i++)
      if (free_ok[i] && 64'(free_ent[i].off) == off + len) begin
        len += 64'(free_ent[i].len);
        free_ok[i] = 1'b0;
        break;
      end
    for (int i = 0; i < FREE_DEPTH; i++)
      if (!free_ok[i]) begin
        slot = i;
        break;
      end
    if (slot >= 0) begin
      free_ent[slot].off = off[31:0];
      free_ent[slot].len = len[31:0];
      free_ok[slot] = 1'b1;
    end
  endfunction

  function automatic outcome_t allocator_predict(logic k, logic [31:0] req, logic [31:0] roff);
    outcome_t    o;
    logic [63:0] need, s;
    int          best, slot, hit;
    o = '0;
    best = -1;
    slot = -1;
    hit = -1;
    if (req == 0) begin
      o.status = ST_ZERO;
    end else if (k == KIND_ALLOC) begin
      need = ((64'(req) + 64'(ALIGN_BYTES - 1)) / 64'(ALIGN_BYTES)) * 64'(ALIGN_BYTES);
      for (int i = 0; i < FREE_DEPTH; i++) begin
        if (!free_ok[i] || 64'(free_ent[i].len) < need) continue;
        if (best < 0 || free_ent[i].len < free_ent[best].len ||
            (free_ent[i].len == free_ent[best].len && free_ent[i].off < free_ent[best].off))
          best = i;
      end
      for (int i = 0; i < LIVE_DEPTH; i++)
        if (!live_ok[i]) begin
          slot = i;
          break;
        end
      if (best < 0) o.status = ST_NO_FIT;
      else if (slot < 0) o.status = ST_FULL;
      else begin
        o.status = ST_OK;
        o.offset = free_ent[best].off;
        o.bytes = need[31:0];
        if (64'(free_ent[best].len) > need) begin
          free_ent[best].off = free_ent[best].off + need[31:0];
          free_ent[best].len = free_ent[best].len - need[31:0];
        end else free_ok[best] = 1'b0;
        live_ent[slot].off = o.offset;
        live_ent[slot].len = need[31:0];
        live_ok[slot] = 1'b1;
        s = 64'(live_bytes) + need;
        live_bytes = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        granted.push_back(o.offset);
      end
    end else begin
      for (int i = 0; i < LIVE_DEPTH; i++)
        if (live_ok[i] && live_ent[i].off == roff) begin
          hit = i;
          break;
        end
      if (hit < 0) o.status = ST_NOT_FOUND;
      else begin
        o.status = ST_OK;
        o.offset = roff;
        o.bytes = live_ent[hit].len;
        live_bytes = (live_bytes >= o.bytes) ? live_bytes - o.bytes : '0;
        live_ok[hit] = 1'b0;
        free_range_merge(64'(roff), 64'(o.bytes));
        foreach (granted[j])
          if (granted[j] == roff) begin
            granted.delete(j);
            break;
          end
      end
    end
    o.free_sum = free_bytes_sum();
    o.live_sum = live_bytes;
    return o;
  endfunction

  // one command transaction; start stays high until the next random gap or drain
  task automatic send_command(logic k, logic [31:0] req, logic [31:0] roff);
    while ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    request_bytes <= req;
    release_offset <= roff;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_outcomes.push_back(allocator_predict(k, req, roff));
  endtask

  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (LIVE_DEPTH + FREE_DEPTH + 20) @(posedge clk);
  endtask

  task automatic write_slab(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tables_reinit(v);
    granted.delete();
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t want, got;
    if (!rst && done) begin
      got = {status, block_offset, block_bytes, free_total, live_total};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic test_directed();
    write_slab(32'h0000_10FF);
    send_command(KIND_ALLOC, 32'd0, 32'd0);
    send_command(KIND_RELEASE, 32'd0, 32'd0);
    send_command(KIND_ALLOC, 32'd1, 32'd0);
    send_command(KIND_ALLOC, 32'd256, 32'd0);
    send_command(KIND_ALLOC, 32'd257, 32'd0);
    send_command(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0);
    send_command(KIND_ALLOC, 32'h0001_0000, 32'd0);
    send_command(KIND_RELEASE, 32'd5, 32'hFFFF_FFFF);
    send_command(KIND_RELEASE, 32'd1, 32'd256);
    send_command(KIND_RELEASE, 32'd1, 32'd256);
    send_command(KIND_RELEASE, 32'hFFFF_FFFF, 32'd0);
    send_command(KIND_RELEASE, 32'd1, 32'd512);
    drain_and_settle();
    // exhaust the live table with tiny grants
    write_slab(32'hFFFF_FFFF);
    for (int i = 0; i < LIVE_DEPTH + 1; i++) send_command(KIND_ALLOC, 32'd1, 32'd0);
    send_command(KIND_ALLOC, 32'hFFFF_FF00, 32'd0);
    drain_and_settle();
    write_slab(32'd0);
    send_command(KIND_ALLOC, 32'd1, 32'd0);
    send_command(KIND_RELEASE, 32'd1, 32'd0);
    drain_and_settle();
  endtask

  task automatic test_random(int n, logic [31:0] slab, int gap_pct);
    logic [31:0] req, roff;
    logic        k;
    int          j;
    send_gap_pct = gap_pct;
    write_slab(slab);
    for (int i = 0; i < n; i++) begin
      k = 1'($urandom_range(1));
      req = ($urandom_range(3) == 0) ? $urandom : $urandom_range(4096, 1);
      if ($urandom_range(19) == 0) req = 0;
      roff = $urandom;
      if (k == KIND_RELEASE && granted.size() != 0 && $urandom_range(9) != 0) begin
        j = int'($urandom_range(granted.size() - 1));
        roff = granted[j];
      end
      send_command(k, req, roff);
    end
    drain_and_settle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(200, 32'h0000_8000, 10);
    test_random(200, 32'h0001_0000, 10);
    test_random(200, 32'h0000_4000, 65);
    test_random(200, 32'hFFFF_FFFF, 65);
    test_random(200, 32'h0000_2000, 0);
    test_random(200, 32'h0000_0100, 0);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
